FILE: hdl/rgbrc_pkg.sv
`timescale 1ns / 1ps

package rgbrc_pkg;

   localparam int COMP_W = 10;
   localparam int PIX_W  = 32;
   localparam int PROD_W = 40;

   // Reciprocal scale: value = (d * K) >> RECIP_SHIFT, exact over the whole clamped span
   localparam int RECIP_SHIFT = 30;

   localparam logic [COMP_W-1:0] LIM_LO  = 10'd64;
   localparam logic [COMP_W-1:0] LIM_HI  = 10'd960;
   localparam logic [COMP_W-1:0] FULL_LO = 10'd4;
   localparam logic [COMP_W-1:0] FULL_HI = 10'd1019;

   // 1015 * ceil(2^30 / 896) and 896 * ceil(2^30 / 1015)
   localparam logic [30:0] K_LIM_TO_FULL = 31'd1216348595;
   localparam logic [30:0] K_FULL_TO_LIM = 31'd947855104;

   localparam logic DIR_LIM_TO_FULL = 1'b0;
   localparam logic DIR_FULL_TO_LIM = 1'b1;

   localparam int RED_LSB   = 22;
   localparam int GREEN_LSB = 12;
   localparam int BLUE_LSB  = 2;

   typedef logic [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic out_load;
   } ctrl_type;

endpackage

FILE: hdl/rgbrc_lane.sv
`timescale 1ns / 1ps

module rgbrc_lane
   import rgbrc_pkg::*;
(
   input  logic     clock,
   input  ctrl_type ctrl,
   input  logic     direction,
   input  comp_type comp_in,
   output comp_type comp_out
);

   comp_type             clamped;
   comp_type             delta_in;
   comp_type             delta_ff;
   logic [30:0]          scale;
   logic [PROD_W-1:0]    prod_in;
   logic [PROD_W-1:0]    prod_ff;
   comp_type             offset;

   // clamp to the source range and remove its floor
   always_comb begin
      if (direction == DIR_LIM_TO_FULL) begin
         if (comp_in < LIM_LO) begin
            clamped = LIM_LO;
         end else if (comp_in > LIM_HI) begin
            clamped = LIM_HI;
         end else begin
            clamped = comp_in;
         end
         delta_in = clamped - LIM_LO;
      end else begin
         if (comp_in < FULL_LO) begin
            clamped = FULL_LO;
         end else if (comp_in > FULL_HI) begin
            clamped = FULL_HI;
         end else begin
            clamped = comp_in;
         end
         delta_in = clamped - FULL_LO;
      end
   end

   assign scale   = (direction == DIR_LIM_TO_FULL) ? K_LIM_TO_FULL : K_FULL_TO_LIM;
   assign prod_in = PROD_W'(delta_ff) * PROD_W'(scale);

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         delta_ff <= delta_in;
      end
      if (ctrl.s2_load) begin
         prod_ff <= prod_in;
      end
   end

   assign offset   = (direction == DIR_LIM_TO_FULL) ? FULL_LO : LIM_LO;
   assign comp_out = prod_ff[RECIP_SHIFT +: COMP_W] + offset;

endmodule

FILE: hdl/rgbrc_merge.sv
`timescale 1ns / 1ps

module rgbrc_merge
   import rgbrc_pkg::*;
(
   input  logic             clock,
   input  ctrl_type         ctrl,
   input  comp_type         red,
   input  comp_type         green,
   input  comp_type         blue,
   input  logic             last_in,
   output logic [PIX_W-1:0] pixel_out,
   output logic             last_out
);

   logic [PIX_W-1:0] pixel_in;
   logic [PIX_W-1:0] pixel_ff;
   logic             last_ff;

   always_comb begin
      pixel_in = '0;
      pixel_in[RED_LSB   +: COMP_W] = red;
      pixel_in[GREEN_LSB +: COMP_W] = green;
      pixel_in[BLUE_LSB  +: COMP_W] = blue;
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         pixel_ff <= pixel_in;
         last_ff  <= last_in;
      end
   end

   assign pixel_out = pixel_ff;
   assign last_out  = last_ff;

endmodule

FILE: hdl/rgb10_range_converter.sv
`timescale 1ns / 1ps
// channel | ports                        | payload
// req     | req_tvalid/tready/tdata/tlast | pixel word in, last marker
// rsp     | rsp_tvalid/tready/tdata/tlast | converted pixel word, last marker
// csr     | csr_valid/ready/data          | direction (0 limited->full, 1 full->limited)
//
// One pixel word per cycle sustained while rsp_tready is high; three register stages
// (s1, s2, output), which an accepted word passes in order before rsp_tvalid rises.
// Stages: clamp and floor removal, reciprocal multiply per lane, offset and repack.
// Each stage advances independently, so bubbles collapse and a held output
// still lets earlier stages fill. Synchronous reset clears valids and direction.

module rgb10_range_converter
   import rgbrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PIX_W-1:0] req_tdata,   // [1:0] pad, [11:2] blue, [21:12] green, [31:22] red
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,   // [1:0] zero, [11:2] blue, [21:12] green, [31:22] red
   output logic             rsp_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   logic     direction_ff, direction_in;
   logic     s1_v_ff, s1_v_in;
   logic     s2_v_ff, s2_v_in;
   logic     out_v_ff, out_v_in;
   logic     last_s1_ff, last_s2_ff;
   logic     out_free, s2_free, s1_free;
   ctrl_type ctrl;
   comp_type red_q, green_q, blue_q;

   assign csr_ready    = 1'b1;
   assign direction_in = (csr_valid && csr_ready) ? csr_data : direction_ff;

   assign out_free = !out_v_ff || rsp_tready;
   assign s2_free  = !s2_v_ff || out_free;
   assign s1_free  = !s1_v_ff || s2_free;

   assign req_tready    = s1_free;
   assign ctrl.s1_load  = req_tvalid && s1_free;
   assign ctrl.s2_load  = s1_v_ff && s2_free;
   assign ctrl.out_load = s2_v_ff && out_free;

   assign s1_v_in  = s1_free  ? req_tvalid : s1_v_ff;
   assign s2_v_in  = s2_free  ? s1_v_ff    : s2_v_ff;
   assign out_v_in = out_free ? s2_v_ff    : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_LIM_TO_FULL;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   // carry the last marker alongside the lane stages
   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         last_s1_ff <= req_tlast;
      end
      if (ctrl.s2_load) begin
         last_s2_ff <= last_s1_ff;
      end
   end

   rgbrc_lane u_lane_red (
      .clock     (clock),
      .ctrl      (ctrl),
      .direction (direction_ff),
      .comp_in   (req_tdata[RED_LSB +: COMP_W]),
      .comp_out  (red_q)
   );

   rgbrc_lane u_lane_green (
      .clock     (clock),
      .ctrl      (ctrl),
      .direction (direction_ff),
      .comp_in   (req_tdata[GREEN_LSB +: COMP_W]),
      .comp_out  (green_q)
   );

   rgbrc_lane u_lane_blue (
      .clock     (clock),
      .ctrl      (ctrl),
      .direction (direction_ff),
      .comp_in   (req_tdata[BLUE_LSB +: COMP_W]),
      .comp_out  (blue_q)
   );

   rgbrc_merge u_merge (
      .clock     (clock),
      .ctrl      (ctrl),
      .red       (red_q),
      .green     (green_q),
      .blue      (blue_q),
      .last_in   (last_s2_ff),
      .pixel_out (rsp_tdata),
      .last_out  (rsp_tlast)
   );

   assign rsp_tvalid = out_v_ff;

endmodule

FILE: hdl/rgbrc_checker.sv
`timescale 1ns / 1ps

module rgbrc_checker
   import rgbrc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [PIX_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   // a held transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] == 2'b00)
      else $error("padding bits not zero");

   a_comp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:22] >= FULL_LO && rsp_tdata[31:22] <= FULL_HI
                  && rsp_tdata[21:12] >= FULL_LO && rsp_tdata[21:12] <= FULL_HI
                  && rsp_tdata[11:2]  >= FULL_LO && rsp_tdata[11:2]  <= FULL_HI)
      else $error("component outside output span");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // an idle pipeline always has room for a new transaction
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind rgb10_range_converter rgbrc_checker u_rgbrc_checker (.*);
